// ===== rtl/mlpta_pkg.sv =====
package mlpta_pkg;

    localparam int BOARD_ROWS_DEF    = 6;
    localparam int BOARD_COLS_DEF    = 7;
    localparam int FIRST_HIDDEN_DEF  = 64;
    localparam int SECOND_HIDDEN_DEF = 32;
    localparam int OUTPUT_COUNT_DEF  = 7;

    localparam int ACC_W = 42;

    localparam logic [28:0] LN2_Q24 = 29'd11629080;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;
    localparam logic [3:0]  SERIES_TERMS = 4'd12;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_CELL  = 1'b1;
    localparam logic [1:0] CELL_EMPTY = 2'b00;
    localparam logic [1:0] CELL_OWN   = 2'b01;
    localparam logic [1:0] CELL_OTHER = 2'b11;

    typedef logic signed [15:0] t_q12;

    typedef struct packed {
        logic start;
        t_q12 arg;
    } t_tanh_req;

    typedef struct packed {
        logic done;
        t_q12 value;
    } t_tanh_rsp;

    function automatic int clog2_min1(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

    // Reciprocals rounded up, ceil(2^30 / n), for the series terms.
    function automatic logic [30:0] recip_q30(input logic [3:0] n);
        logic [30:0] r;
        case (n)
            4'd1:    r = 31'd1073741824;
            4'd2:    r = 31'd536870912;
            4'd3:    r = 31'd357913942;
            4'd4:    r = 31'd268435456;
            4'd5:    r = 31'd214748365;
            4'd6:    r = 31'd178956971;
            4'd7:    r = 31'd153391690;
            4'd8:    r = 31'd134217728;
            4'd9:    r = 31'd119304648;
            4'd10:   r = 31'd107374183;
            4'd11:   r = 31'd97612894;
            4'd12:   r = 31'd89478486;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mlpta_req_if.sv =====
interface mlpta_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [12:0]       weight_addr;
    logic signed [15:0] weight_value;
    logic [1:0]        cell_color;
    logic [1:0]        own_color;
    logic              last_cell;

    modport source (
        output valid, req_type, weight_addr, weight_value, cell_color, own_color, last_cell,
        input  ready
    );
    modport sink (
        input  valid, req_type, weight_addr, weight_value, cell_color, own_color, last_cell,
        output ready
    );
endinterface

// ===== rtl/mlpta_rsp_if.sv =====
interface mlpta_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] chosen_column;

    modport source (output valid, chosen_column, input ready);
    modport sink (input valid, chosen_column, output ready);
endinterface

// ===== rtl/mlpta_tanh.sv =====
module mlpta_tanh import mlpta_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tanh_req i_req,
    output t_tanh_rsp o_rsp
);

    typedef enum logic [2:0] {T_IDLE, T_K, T_M0, T_M1, T_MR, T_QS, T_E, T_DV} t_state;

    t_state       r_state;
    logic         r_done;
    t_q12         r_value;
    logic         r_neg;
    logic [28:0]  r_r;
    logic [4:0]   r_k;
    logic [24:0]  r_t;
    logic [25:0]  r_s;
    logic [3:0]   r_n;
    logic [36:0]  r_plo;
    logic [24:0]  r_x;
    logic [55:0]  r_m;
    logic [39:0]  r_num;
    logic [26:0]  r_den;
    logic [3:0]   r_bit;
    logic [12:0]  r_q;

    logic [15:0]  w_mag;
    logic [36:0]  w_plo;
    logic [36:0]  w_phi;
    logic [48:0]  w_psum;
    logic [55:0]  w_m;
    logic [24:0]  w_tn;
    logic [25:0]  w_eraw;
    logic [24:0]  w_e;
    logic [39:0]  w_dsh;
    logic         w_hit;
    logic [12:0]  w_qn;

    assign w_mag  = i_req.arg[15] ? 16'(~i_req.arg + 16'sd1) : 16'(i_req.arg);
    assign w_plo  = r_t * r_r[11:0];
    assign w_phi  = r_t * r_r[23:12];
    assign w_psum = {w_phi, 12'd0} + 49'(r_plo);
    assign w_m    = r_x * recip_q30(r_n);
    assign w_tn   = r_m[54:30];
    assign w_eraw = r_s >> r_k;
    assign w_e    = (w_eraw > 26'(ONE_Q24)) ? ONE_Q24 : w_eraw[24:0];
    assign w_dsh  = 40'(r_den) << r_bit;
    assign w_hit  = (r_num >= w_dsh);
    assign w_qn   = r_q | (13'(w_hit) << r_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.arg[15];
                        r_r     <= {w_mag, 13'd0};
                        r_k     <= 5'd0;
                        r_state <= T_K;
                    end
                end
                T_K: begin
                    if (r_r >= LN2_Q24) begin
                        r_r <= r_r - LN2_Q24;
                        r_k <= r_k + 5'd1;
                    end else begin
                        r_t     <= ONE_Q24;
                        r_s     <= 26'(ONE_Q24);
                        r_n     <= 4'd1;
                        r_state <= T_M0;
                    end
                end
                T_M0: begin
                    r_plo   <= w_plo;
                    r_state <= T_M1;
                end
                T_M1: begin
                    r_x     <= w_psum[48:24];
                    r_state <= T_MR;
                end
                T_MR: begin
                    r_m     <= w_m;
                    r_state <= T_QS;
                end
                T_QS: begin
                    r_t <= w_tn;
                    if (r_n[0]) begin
                        r_s <= r_s - 26'(w_tn);
                    end else begin
                        r_s <= r_s + 26'(w_tn);
                    end
                    if (r_n == SERIES_TERMS) begin
                        r_state <= T_E;
                    end else begin
                        r_n     <= r_n + 4'd1;
                        r_state <= T_M0;
                    end
                end
                T_E: begin
                    r_num   <= (40'(ONE_Q24 - w_e) << 13) + 40'(26'(ONE_Q24) + 26'(w_e));
                    r_den   <= 27'(26'(ONE_Q24) + 26'(w_e)) << 1;
                    r_bit   <= 4'd12;
                    r_q     <= 13'd0;
                    r_state <= T_DV;
                end
                T_DV: begin
                    if (w_hit) begin
                        r_num <= r_num - w_dsh;
                    end
                    r_q <= w_qn;
                    if (r_bit == 4'd0) begin
                        r_value <= r_neg ? -t_q12'({3'd0, w_qn}) : t_q12'({3'd0, w_qn});
                        r_done  <= 1'b1;
                        r_state <= T_IDLE;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

// ===== rtl/mlp_tanh_argmax_inference_unit.sv =====
// Channel   Modport  Beat contents
// i_req     sink     req_type, weight_addr, weight_value, cell_color, own_color, last_cell
// o_rsp     source   chosen_column
//
// A last cell starts an evaluation that runs one MAC over the weight memory: per neuron it
// issues every input weight and then the bias, drains the multiply pipeline and waits for
// the tanh unit, whose result goes to the next layer or, in the output layer, to the argmax.
// Reset clears the control state only; the memories hold nothing defined until written.
// No beat is taken during an evaluation; a write or cell may be taken while a result waits.
module mlp_tanh_argmax_inference_unit import mlpta_pkg::*; #(
    parameter int BOARD_ROWS    = BOARD_ROWS_DEF,
    parameter int BOARD_COLS    = BOARD_COLS_DEF,
    parameter int FIRST_HIDDEN  = FIRST_HIDDEN_DEF,
    parameter int SECOND_HIDDEN = SECOND_HIDDEN_DEF,
    parameter int OUTPUT_COUNT  = OUTPUT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlpta_req_if.sink   i_req,
    mlpta_rsp_if.source o_rsp
);

    localparam int NC   = BOARD_ROWS * BOARD_COLS;
    localparam int L1   = FIRST_HIDDEN * (NC + 1);
    localparam int L2   = SECOND_HIDDEN * (FIRST_HIDDEN + 1);
    localparam int L3   = OUTPUT_COUNT * (SECOND_HIDDEN + 1);
    localparam int WD   = L1 + L2 + L3;
    localparam int WAW  = clog2_min1(WD);
    localparam int PW   = $clog2(WD + 1);
    localparam int MAXP = (NC > FIRST_HIDDEN) ? ((NC > SECOND_HIDDEN) ? NC : SECOND_HIDDEN)
                        : ((FIRST_HIDDEN > SECOND_HIDDEN) ? FIRST_HIDDEN : SECOND_HIDDEN);
    localparam int MAXC = (FIRST_HIDDEN > SECOND_HIDDEN)
                        ? ((FIRST_HIDDEN > OUTPUT_COUNT) ? FIRST_HIDDEN : OUTPUT_COUNT)
                        : ((SECOND_HIDDEN > OUTPUT_COUNT) ? SECOND_HIDDEN : OUTPUT_COUNT);
    localparam int IW   = $clog2(MAXP + 1);
    localparam int NW   = $clog2(MAXC + 1);
    localparam int BAW  = clog2_min1(NC);
    localparam int H1W  = clog2_min1(FIRST_HIDDEN);
    localparam int H2W  = clog2_min1(SECOND_HIDDEN);
    localparam int CW   = $clog2(NC + 1);
    localparam int OIW  = clog2_min1(OUTPUT_COUNT);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_TANH, S_HOLD} t_state;
    typedef enum logic [1:0] {L_FIRST, L_SECOND, L_OUT} t_layer;

    t_q12 m_weight [WD];
    logic [1:0] m_board [NC];
    t_q12 m_h1 [FIRST_HIDDEN];
    t_q12 m_h2 [SECOND_HIDDEN];

    t_state            r_state;
    t_layer            r_layer;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_i;
    logic [NW-1:0]     r_n;
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_bptr;
    logic              r_p1_valid;
    logic              r_p1_bias;
    logic              r_p1_gate;
    logic              r_p2_valid;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic              r_tstart;
    t_q12              r_best;
    logic [OIW-1:0]    r_best_idx;
    logic              r_out_valid;
    logic [2:0]        r_out_col;
    t_q12              r_w_q;
    logic [1:0]        r_b_q;
    t_q12              r_h1_q;
    t_q12              r_h2_q;

    logic              w_accept;
    logic              w_wr_en;
    logic [WAW-1:0]    w_rd_addr;
    logic [1:0]        w_code;
    logic [IW-1:0]     w_nprev;
    logic [NW-1:0]     w_ncur;
    logic              w_last_in;
    t_q12              w_act;
    logic signed [31:0] w_prod;
    logic signed [ACC_W-1:0] w_v;
    logic signed [ACC_W-1:0] w_sh;
    t_q12              w_sat;
    t_tanh_req         w_treq;
    t_tanh_rsp         w_trsp;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_wr_en     = w_accept && (i_req.req_type == REQ_WRITE)
                         && (32'(i_req.weight_addr) < 32'(WD));

    always_comb begin
        case (r_layer)
            L_FIRST: begin
                w_nprev = IW'(NC);
                w_ncur  = NW'(FIRST_HIDDEN);
            end
            L_SECOND: begin
                w_nprev = IW'(FIRST_HIDDEN);
                w_ncur  = NW'(SECOND_HIDDEN);
            end
            L_OUT: begin
                w_nprev = IW'(SECOND_HIDDEN);
                w_ncur  = NW'(OUTPUT_COUNT);
            end
            default: begin
                w_nprev = IW'(NC);
                w_ncur  = NW'(FIRST_HIDDEN);
            end
        endcase
    end

    assign w_last_in = (r_i == w_nprev);
    assign w_rd_addr = w_last_in ? r_bptr[WAW-1:0] : r_wptr[WAW-1:0];

    always_comb begin
        if (i_req.cell_color == 2'd0) begin
            w_code = CELL_EMPTY;
        end else if (i_req.cell_color == i_req.own_color) begin
            w_code = CELL_OWN;
        end else begin
            w_code = CELL_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            m_weight[WAW'(i_req.weight_addr)] <= i_req.weight_value;
        end
        r_w_q <= m_weight[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.req_type == REQ_CELL) && (32'(r_count) < 32'(NC))) begin
            m_board[r_count[BAW-1:0]] <= w_code;
        end
        r_b_q <= m_board[r_i[BAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_trsp.done && (r_layer == L_FIRST)) begin
            m_h1[r_n[H1W-1:0]] <= w_trsp.value;
        end
        r_h1_q <= m_h1[r_i[H1W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_trsp.done && (r_layer == L_SECOND)) begin
            m_h2[r_n[H2W-1:0]] <= w_trsp.value;
        end
        r_h2_q <= m_h2[r_i[H2W-1:0]];
    end

    always_comb begin
        if (r_p1_bias) begin
            w_act = 16'sd4096;
        end else begin
            case (r_layer)
                L_FIRST: begin
                    if (!r_p1_gate || !r_b_q[0]) begin
                        w_act = 16'sd0;
                    end else if (r_b_q[1]) begin
                        w_act = -16'sd4096;
                    end else begin
                        w_act = 16'sd4096;
                    end
                end
                L_SECOND: w_act = r_h1_q;
                L_OUT:    w_act = r_h2_q;
                default:  w_act = 16'sd0;
            endcase
        end
    end

    assign w_prod = r_w_q * w_act;
    assign w_v    = r_acc + ACC_W'(2048);
    assign w_sh   = w_v >>> 12;

    always_comb begin
        if (w_sh > ACC_W'(32767)) begin
            w_sat = 16'sh7fff;
        end else if (w_sh < -ACC_W'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sh[15:0];
        end
    end

    assign w_treq.start = r_tstart;
    assign w_treq.arg   = w_sat;

    mlpta_tanh u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_treq),
        .o_rsp   (w_trsp)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_p2_valid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_ISSUE) begin
            r_p1_bias <= w_last_in;
            r_p1_gate <= (32'(r_i) < 32'(r_count));
        end
        if ((r_state == S_IDLE) || (r_state == S_TANH)) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_layer     <= L_FIRST;
            r_count     <= '0;
            r_i         <= '0;
            r_n         <= '0;
            r_wptr      <= '0;
            r_bptr      <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_tstart    <= 1'b0;
            r_best      <= '0;
            r_best_idx  <= '0;
            r_out_valid <= 1'b0;
            r_out_col   <= '0;
        end else begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= r_p1_valid;
            r_tstart   <= 1'b0;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_req.req_type == REQ_CELL)) begin
                        if (32'(r_count) < 32'(NC)) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_req.last_cell) begin
                            r_layer <= L_FIRST;
                            r_n     <= '0;
                            r_i     <= '0;
                            r_wptr  <= '0;
                            r_bptr  <= PW'(FIRST_HIDDEN * NC);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_p1_valid <= 1'b1;
                    if (w_last_in) begin
                        r_bptr  <= r_bptr + PW'(1);
                        r_state <= S_DRAIN;
                    end else begin
                        r_wptr <= r_wptr + PW'(1);
                        r_i    <= r_i + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_valid && !r_p2_valid) begin
                        r_tstart <= 1'b1;
                        r_state  <= S_TANH;
                    end
                end
                S_TANH: begin
                    if (w_trsp.done) begin
                        if (r_layer == L_OUT) begin
                            if ((r_n == '0) || (w_trsp.value > r_best)) begin
                                r_best     <= w_trsp.value;
                                r_best_idx <= r_n[OIW-1:0];
                            end
                        end
                        r_i <= '0;
                        if (r_n == NW'(w_ncur - NW'(1))) begin
                            r_n <= '0;
                            case (r_layer)
                                L_FIRST: begin
                                    r_layer <= L_SECOND;
                                    r_wptr  <= PW'(L1);
                                    r_bptr  <= PW'(L1 + SECOND_HIDDEN * FIRST_HIDDEN);
                                    r_state <= S_ISSUE;
                                end
                                L_SECOND: begin
                                    r_layer <= L_OUT;
                                    r_wptr  <= PW'(L1 + L2);
                                    r_bptr  <= PW'(L1 + L2 + OUTPUT_COUNT * SECOND_HIDDEN);
                                    r_state <= S_ISSUE;
                                end
                                default: r_state <= S_HOLD;
                            endcase
                        end else begin
                            r_n     <= r_n + NW'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= 3'(r_best_idx);
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.chosen_column = r_out_col;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import mlpta_pkg::*;

    localparam int N_CELLS  = BOARD_ROWS_DEF * BOARD_COLS_DEF;
    localparam int N_HID1   = FIRST_HIDDEN_DEF;
    localparam int N_HID2   = SECOND_HIDDEN_DEF;
    localparam int N_OUT    = OUTPUT_COUNT_DEF;
    localparam int L1_WORDS = N_HID1 * (N_CELLS + 1);
    localparam int L2_WORDS = N_HID2 * (N_HID1 + 1);
    localparam int L3_WORDS = N_OUT * (N_HID2 + 1);
    localparam int W_DEPTH  = L1_WORDS + L2_WORDS + L3_WORDS;
    localparam int L3_BASE  = L1_WORDS + L2_WORDS;
    localparam int Q12_ONE  = 4096;

    localparam logic [1:0] COLOUR_FIRST  = 2'd1;
    localparam logic [1:0] COLOUR_SECOND = 2'd2;
    localparam logic [1:0] COLOUR_BAD    = 2'd3;

    typedef struct {
        logic        kind;
        logic [12:0] addr;
        logic [15:0] value;
        logic [1:0]  colour;
        logic [1:0]  own;
        logic        last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    mlpta_req_if req_if ();
    mlpta_rsp_if rsp_if ();

    mlp_tanh_argmax_inference_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    int          weights [W_DEPTH];
    int          board [N_CELLS];
    int          cells_taken;
    int          acts_in [64];
    int          acts_out [64];
    logic [2:0]  expected_columns [$];
    int          fail_count;
    int          rsp_hold_cycles;
    int          rsp_stall;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int tanh_q12(input int q);
        longint unsigned mag, y, k, r, s, t, e, num, den;
        int res;
        mag = (q < 0) ? -q : q;
        y = (mag * 2) << 12;
        k = y / 64'd11629080;
        r = y - k * 64'd11629080;
        s = 64'd1 << 24;
        t = s;
        for (int n = 1; n <= 12; n++) begin
            t = ((t * r) >> 24) / n;
            if (n % 2 == 1) s = s - t;
            else s = s + t;
        end
        e = (k >= 63) ? 0 : (s >> k);
        if (e > (64'd1 << 24)) e = 64'd1 << 24;
        num = ((64'd1 << 24) - e) * 8192 + ((64'd1 << 24) + e);
        den = 2 * ((64'd1 << 24) + e);
        res = int'(num / den);
        return (q < 0) ? -res : res;
    endfunction

    function automatic int round_to_q12(input longint sum);
        longint v, q;
        v = sum + 2048;
        if (v >= 0) q = v >>> 12;
        else q = -((-v + 4095) >>> 12);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic void dense_layer(input int n_prev, input int n_cur, input int base);
        longint sum;
        for (int n = 0; n < n_cur; n++) begin
            sum = 0;
            for (int i = 0; i < n_prev; i++)
                sum += longint'(weights[base + n * n_prev + i]) * acts_in[i];
            sum += longint'(weights[base + n_cur * n_prev + n]) * Q12_ONE;
            acts_out[n] = tanh_q12(round_to_q12(sum));
        end
        for (int n = 0; n < n_cur; n++) acts_in[n] = acts_out[n];
    endfunction

    function automatic logic [2:0] choose_column();
        int best;
        int best_idx;
        for (int i = 0; i < N_CELLS; i++) acts_in[i] = board[i];
        dense_layer(N_CELLS, N_HID1, 0);
        dense_layer(N_HID1, N_HID2, L1_WORDS);
        dense_layer(N_HID2, N_OUT, L3_BASE);
        best = acts_in[0];
        best_idx = 0;
        for (int i = 1; i < N_OUT; i++) begin
            if (acts_in[i] > best) begin
                best = acts_in[i];
                best_idx = i;
            end
        end
        return best_idx[2:0];
    endfunction

    function automatic void apply_beat(input t_beat b);
        if (b.kind == REQ_WRITE) begin
            if (b.addr < W_DEPTH) weights[b.addr] = int'($signed(b.value));
            return;
        end
        if (cells_taken < N_CELLS) begin
            if (b.colour == CELL_EMPTY) board[cells_taken] = 0;
            else if (b.colour == b.own) board[cells_taken] = Q12_ONE;
            else board[cells_taken] = -Q12_ONE;
            cells_taken++;
        end
        if (b.last) begin
            expected_columns.push_back(choose_column());
            for (int i = 0; i < N_CELLS; i++) board[i] = 0;
            cells_taken = 0;
        end
    endfunction

    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(input t_beat b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= b.kind;
        req_if.weight_addr  <= b.addr;
        req_if.weight_value <= b.value;
        req_if.cell_color   <= b.colour;
        req_if.own_color    <= b.own;
        req_if.last_cell    <= b.last;
        do @(posedge i_clk); while (!req_if.ready);
        apply_beat(b);
    endtask

    task automatic send_write(input int addr, input logic [15:0] value);
        t_beat b;
        b.kind   = REQ_WRITE;
        b.addr   = addr[12:0];
        b.value  = value;
        b.colour = 2'($urandom);
        b.own    = 2'($urandom);
        b.last   = 1'($urandom);
        send_beat(b);
    endtask

    task automatic send_cell(input logic [1:0] colour, input logic [1:0] own, input logic last);
        t_beat b;
        b.kind   = REQ_CELL;
        b.addr   = 13'($urandom);
        b.value  = 16'($urandom);
        b.colour = colour;
        b.own    = own;
        b.last   = last;
        send_beat(b);
    endtask

    function automatic logic [15:0] random_weight(input int addr);
        int p;
        p = $urandom_range(0, 99);
        if (p < 2) return 16'h8000;
        if (p < 4) return 16'h7fff;
        if (p < 8) return 16'($urandom);
        if (addr < L1_WORDS) return 16'($signed($urandom_range(0, 3000)) - 1500);
        return 16'($signed($urandom_range(0, 6000)) - 3000);
    endfunction

    task automatic send_random_board(input int n_cells, input logic [1:0] own);
        logic [1:0] c;
        for (int i = 0; i < n_cells; i++) begin
            c = ($urandom_range(0, 19) == 0) ? COLOUR_BAD : 2'($urandom_range(0, 2));
            send_cell(c, own, i == n_cells - 1);
        end
    endtask

    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= 0;
        end else if (rsp_hold_cycles > 0) begin
            rsp_if.ready    <= 1'b0;
            rsp_hold_cycles <= rsp_hold_cycles - 1;
        end else if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 5) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : 0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_columns.size() == 0) begin
                report_mismatch($sformatf("unexpected column %0d", rsp_if.chosen_column));
            end else begin
                if (rsp_if.chosen_column !== expected_columns[0])
                    report_mismatch($sformatf("column %0d, expected %0d",
                                              rsp_if.chosen_column, expected_columns[0]));
                void'(expected_columns.pop_front());
            end
        end
    end

    task automatic test_weight_load();
        for (int a = 0; a < W_DEPTH; a++) send_write(a, random_weight(a));
    endtask

    task automatic test_ignored_writes();
        send_write(W_DEPTH, 16'h7fff);
        send_write(8191, 16'h8000);
        send_write($urandom_range(W_DEPTH, 8191), 16'($urandom));
        send_random_board(N_CELLS, COLOUR_FIRST);
    endtask

    task automatic test_board_encodings();
        for (int i = 0; i < N_CELLS; i++) send_cell(COLOUR_FIRST, COLOUR_FIRST, i == N_CELLS - 1);
        for (int i = 0; i < N_CELLS; i++) send_cell(COLOUR_FIRST, COLOUR_SECOND, i == N_CELLS - 1);
        for (int i = 0; i < N_CELLS; i++) send_cell(CELL_EMPTY, COLOUR_SECOND, i == N_CELLS - 1);
        for (int i = 0; i < N_CELLS; i++) send_cell(COLOUR_BAD, COLOUR_BAD, i == N_CELLS - 1);
        send_random_board(N_CELLS, 2'd0);
        send_random_board(N_CELLS, COLOUR_SECOND);
    endtask

    task automatic test_short_and_long_boards();
        send_cell(COLOUR_SECOND, COLOUR_FIRST, 1'b1);
        send_random_board(5, COLOUR_FIRST);
        send_random_board(N_CELLS + 9, COLOUR_SECOND);
    endtask

    task automatic test_output_ties();
        for (int a = L3_BASE; a < W_DEPTH; a++) send_write(a, 16'h0000);
        send_random_board(N_CELLS, COLOUR_FIRST);
        send_write(W_DEPTH - 1, 16'h7fff);
        send_write(W_DEPTH - 2, 16'h7fff);
        send_random_board(N_CELLS, COLOUR_FIRST);
        for (int a = L3_BASE; a < W_DEPTH; a++) send_write(a, random_weight(a));
    endtask

    task automatic test_writes_while_result_waits();
        wait_results_drained();
        rsp_hold_cycles <= 20000;
        send_random_board(N_CELLS, COLOUR_FIRST);
        for (int i = 0; i < 20; i++) begin
            int a;
            a = $urandom_range(0, W_DEPTH - 1);
            send_write(a, random_weight(a));
        end
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        rsp_hold_cycles <= 40000;
        no_idle = 1'b1;
        send_random_board(N_CELLS, COLOUR_SECOND);
        send_random_board(N_CELLS, COLOUR_FIRST);
        send_random_board(N_CELLS, COLOUR_SECOND);
        no_idle = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_random_games();
        int p;
        int a;
        for (int g = 0; g < 36; g++) begin
            no_idle = (g % 9 == 4);
            for (int w = $urandom_range(0, 12); w > 0; w--) begin
                a = ($urandom_range(0, 9) == 0) ? $urandom_range(W_DEPTH, 8191)
                                                 : $urandom_range(0, W_DEPTH - 1);
                send_write(a, random_weight(a));
            end
            p = $urandom_range(0, 99);
            if (p < 80) send_random_board(N_CELLS, COLOUR_FIRST + 2'($urandom_range(0, 1)));
            else if (p < 90) send_random_board($urandom_range(1, N_CELLS - 1), 2'($urandom));
            else send_random_board($urandom_range(N_CELLS + 1, N_CELLS + 6), 2'($urandom));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        fail_count      = 0;
        cells_taken     = 0;
        no_idle         = 1'b0;
        rsp_hold_cycles = 0;
        for (int i = 0; i < N_CELLS; i++) board[i] = 0;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_WRITE;
        req_if.weight_addr  <= '0;
        req_if.weight_value <= '0;
        req_if.cell_color   <= CELL_EMPTY;
        req_if.own_color    <= COLOUR_FIRST;
        req_if.last_cell    <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_weight_load();
        test_ignored_writes();
        test_board_encodings();
        test_short_and_long_boards();
        test_output_ties();
        test_writes_while_result_waits();
        test_backpressure();
        test_random_games();

        wait_results_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mlpta_pkg.sv
rtl/mlpta_req_if.sv
rtl/mlpta_rsp_if.sv
rtl/mlpta_tanh.sv
rtl/mlp_tanh_argmax_inference_unit.sv
test/tb.sv
